// File: rtl/mft_pkg.sv
`default_nettype none

package mft_pkg;

    // Slot geometry and encoder resolution
    localparam int SLOTS           = 8;
    localparam int SLOT_W          = 3;
    localparam int COUNTS_PER_TURN = 8192;
    localparam int HALF_TURN       = COUNTS_PER_TURN / 2;

    // Feedback identifier window
    localparam logic [10:0] FIRST_ID = 11'h201;
    localparam logic [10:0] LAST_ID  = 11'h208;

    // Counter saturation points
    localparam logic [7:0] CNT8_MAX    = 8'd255;
    localparam logic [4:0] TIMEOUT_MAX = 5'd31;

    // Configuration reset values
    localparam logic [3:0]  RST_IN_USE    = 4'd8;
    localparam logic [3:0]  RST_SMALL     = 4'd4;
    localparam logic [12:0] RST_STEP_LIM  = 13'd5;
    localparam logic [14:0] RST_CUR_LIM   = 15'd3000;
    localparam logic [7:0]  RST_STALL_TK  = 8'd100;
    localparam logic [7:0]  RST_SILENCE   = 8'd50;
    localparam logic [4:0]  RST_TIMEOUT   = 5'd20;
    localparam logic        RST_STOP      = 1'b1;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [1:0] {
        CMD_FRAME = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_ZERO  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_USE   = 4'd0,
        CFG_SMALL    = 4'd1,
        CFG_STEP_LIM = 4'd2,
        CFG_CUR_LIM  = 4'd3,
        CFG_STALL_TK = 4'd4,
        CFG_SILENCE  = 4'd5,
        CFG_TIMEOUT  = 4'd6,
        CFG_STOP     = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        t_cmd        command;
        logic [10:0] frame_id;
        logic        extended_id;
        logic        remote_frame;
        logic [15:0] angle_word;
        logic [15:0] speed_word;
        logic [15:0] current_word;
        logic [7:0]  temperature_byte;
        logic [2:0]  slot;
    } t_in;

    typedef struct packed {
        logic               accepted;
        logic [2:0]         slot_out;
        logic signed [31:0] total_count;
        logic signed [15:0] last_step;
        logic signed [15:0] motor_speed;
        logic signed [15:0] motor_current;
        logic signed [7:0]  temperature;
        logic               temperature_valid;
        logic               stall_flag;
        logic               timeout_flag;
        logic               disable_request;
    } t_out;

    typedef struct packed {
        logic [3:0]  motors_in_use;
        logic [3:0]  small_motor_count;
        logic [12:0] stall_step_limit;
        logic [14:0] stall_current_limit;
        logic [7:0]  stall_ticks;
        logic [7:0]  silence_ticks;
        logic [4:0]  timeout_ticks;
        logic        stop_on_stall;
    } t_cfg;

    // Per-motor tracking state; flags bit 0 is stall, bit 1 is timeout
    typedef struct packed {
        logic [15:0] prev_reading;
        logic [31:0] total;
        logic [15:0] step;
        logic [15:0] current;
        logic [7:0]  stall_cnt;
        logic [7:0]  silence_cnt;
        logic [4:0]  timeout_cnt;
        logic [1:0]  flags;
    } t_slot;

endpackage

`default_nettype wire

// File: rtl/motor_feedback_tracker.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        slave      i_in_valid / o_in_ready    i_in_data   (mft_pkg::t_in)
// out       master     o_out_valid / i_out_ready  o_out_data  (mft_pkg::t_out)
// cfg       slave      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; a result passes from the input register
// into the result register and leaves from there.
// The per-slot read-modify-write (step unwrap and 32-bit add) sits between the
// input register and the result register; state lives in flip-flops per slot.
// Synchronous active-low reset clears all slot state and loads config defaults.
// A stalled output holds its result; the input register still empties into it
// in the same cycle the result is taken. The cfg port is always ready.
module motor_feedback_tracker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  mft_pkg::t_in                        i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output mft_pkg::t_out                       o_out_data,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [mft_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [mft_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import mft_pkg::*;

    t_cfg              r_cfg;
    t_slot             r_st [SLOTS];
    logic              r_in_valid;
    t_in               r_in;
    logic              r_out_valid;
    t_out              r_out;

    logic              advance;
    logic [SLOT_W-1:0] upd_slot;
    logic              upd_write;
    t_slot             upd_state;
    t_out              upd_result;

    // Pipeline flow control
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.motors_in_use       <= RST_IN_USE;
            r_cfg.small_motor_count   <= RST_SMALL;
            r_cfg.stall_step_limit    <= RST_STEP_LIM;
            r_cfg.stall_current_limit <= RST_CUR_LIM;
            r_cfg.stall_ticks         <= RST_STALL_TK;
            r_cfg.silence_ticks       <= RST_SILENCE;
            r_cfg.timeout_ticks       <= RST_TIMEOUT;
            r_cfg.stop_on_stall       <= RST_STOP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IN_USE:   r_cfg.motors_in_use       <= i_cfg_data[3:0];
                CFG_SMALL:    r_cfg.small_motor_count   <= i_cfg_data[3:0];
                CFG_STEP_LIM: r_cfg.stall_step_limit    <= i_cfg_data[12:0];
                CFG_CUR_LIM:  r_cfg.stall_current_limit <= i_cfg_data[14:0];
                CFG_STALL_TK: r_cfg.stall_ticks         <= i_cfg_data[7:0];
                CFG_SILENCE:  r_cfg.silence_ticks       <= i_cfg_data[7:0];
                CFG_TIMEOUT:  r_cfg.timeout_ticks       <= i_cfg_data[4:0];
                CFG_STOP:     r_cfg.stop_on_stall       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Slot update logic
    mft_update u_update (
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .i_state  (r_st[upd_slot]),
        .o_slot   (upd_slot),
        .o_write  (upd_write),
        .o_state  (upd_state),
        .o_result (upd_result)
    );

    // Per-slot state write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_st[k] <= '0;
            end
        end else if (advance && upd_write) begin
            r_st[upd_slot] <= upd_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= upd_result;
        end
    end

    // Checks
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.accepted |->
            o_out_data.total_count == 0 && !o_out_data.stall_flag
            && !o_out_data.timeout_flag && !o_out_data.disable_request)
        else $error("rejected item carries nonzero result");

    a_disable_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.disable_request |->
            o_out_data.stall_flag || o_out_data.timeout_flag)
        else $error("disable request without a sticky flag");

    a_temp_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.temperature_valid |->
            o_out_data.accepted && !o_out_data.disable_request)
        else $error("temperature valid on a non-frame result");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("transfer into result register lost");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("input not ready while input register empty");

endmodule

`default_nettype wire

// File: rtl/mft_update.sv
`default_nettype none

module mft_update (
    input  mft_pkg::t_in                 i_item,
    input  mft_pkg::t_cfg                i_cfg,
    input  mft_pkg::t_slot               i_state,
    output logic [mft_pkg::SLOT_W-1:0]   o_slot,
    output logic                         o_write,
    output mft_pkg::t_slot               o_state,
    output mft_pkg::t_out                o_result
);
    import mft_pkg::*;

    localparam logic signed [15:0] HALF_POS = 16'(HALF_TURN);
    localparam logic signed [15:0] HALF_NEG = -16'(HALF_TURN);
    localparam logic [15:0]        CPT_16   = 16'(COUNTS_PER_TURN);

    logic              is_frame;
    logic              frame_ok;
    logic [SLOT_W-1:0] id_off;
    logic [SLOT_W-1:0] slot;
    logic              in_use;
    logic              apply;
    logic [15:0]       diff;
    logic [15:0]       gap;
    logic              stall_cond;
    logic              temp_ok;
    logic              dis;
    t_slot             nxt;

    // Frame filter and slot selection
    assign is_frame = (i_item.command == CMD_FRAME);
    assign frame_ok = !i_item.extended_id && !i_item.remote_frame
                      && (i_item.frame_id >= FIRST_ID) && (i_item.frame_id <= LAST_ID);
    assign id_off   = SLOT_W'(i_item.frame_id - FIRST_ID);
    assign slot     = is_frame ? id_off : i_item.slot;
    assign in_use   = ({1'b0, slot} < i_cfg.motors_in_use)
                      && ({1'b0, slot} < 4'(SLOTS));
    assign apply    = in_use && (!is_frame || frame_ok);
    assign temp_ok  = ({1'b0, slot} + 4'd1) > i_cfg.small_motor_count;

    // Encoder step, folded back into half a turn
    assign diff = i_item.angle_word - i_state.prev_reading;
    always_comb begin
        if ($signed(diff) > HALF_POS) begin
            gap = diff - CPT_16;
        end else if ($signed(diff) < HALF_NEG) begin
            gap = diff + CPT_16;
        end else begin
            gap = diff;
        end
    end

    // Stall condition on the stored step and current
    assign stall_cond = ($signed(i_state.step) < $signed({3'b000, i_cfg.stall_step_limit}))
                        && ($signed(i_state.current)
                            > $signed({1'b0, i_cfg.stall_current_limit}));

    // Next slot state per command
    always_comb begin
        nxt = i_state;
        dis = 1'b0;
        unique case (i_item.command)
            CMD_FRAME: begin
                nxt.total        = i_state.total + {{16{gap[15]}}, gap};
                nxt.step         = gap;
                nxt.current      = i_item.current_word;
                nxt.prev_reading = i_item.angle_word;
                nxt.silence_cnt  = '0;
            end
            CMD_TICK: begin
                // stall detection
                if (stall_cond) begin
                    if (i_state.stall_cnt > i_cfg.stall_ticks) begin
                        nxt.stall_cnt = '0;
                        nxt.flags[0]  = 1'b1;
                        dis           = i_cfg.stop_on_stall;
                    end else if (i_state.stall_cnt != CNT8_MAX) begin
                        nxt.stall_cnt = i_state.stall_cnt + 8'd1;
                    end
                end else begin
                    nxt.stall_cnt = '0;
                end
                // receive timeout detection
                if (i_state.silence_cnt != CNT8_MAX) begin
                    nxt.silence_cnt = i_state.silence_cnt + 8'd1;
                end
                if (i_state.silence_cnt > i_cfg.silence_ticks) begin
                    if (i_state.timeout_cnt > i_cfg.timeout_ticks) begin
                        nxt.timeout_cnt = '0;
                        nxt.flags[1]    = 1'b1;
                        dis             = 1'b1;
                    end else if (i_state.timeout_cnt != TIMEOUT_MAX) begin
                        nxt.timeout_cnt = i_state.timeout_cnt + 5'd1;
                    end
                end
            end
            CMD_ZERO: begin
                nxt.total = '0;
            end
            CMD_CLEAR: begin
                nxt.flags = '0;
            end
            default: begin
                nxt = i_state;
            end
        endcase
    end

    assign o_slot  = slot;
    assign o_write = apply;
    assign o_state = nxt;

    // Result; a rejected item reports all zeros
    always_comb begin
        o_result = '0;
        if (apply) begin
            o_result.accepted        = 1'b1;
            o_result.slot_out        = slot;
            o_result.total_count     = nxt.total;
            o_result.last_step       = nxt.step;
            o_result.motor_current   = nxt.current;
            o_result.stall_flag      = nxt.flags[0];
            o_result.timeout_flag    = nxt.flags[1];
            o_result.disable_request = dis;
            if (is_frame) begin
                o_result.motor_speed = i_item.speed_word;
                if (temp_ok) begin
                    o_result.temperature       = i_item.temperature_byte;
                    o_result.temperature_valid = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire
